FILE: hdl/vnorm_pkg.sv
// ----------------------------------------------------------------------------
// vnorm_pkg: shared constants for the 2D vector normalizer
// Default component width, register map and register reset values.
// ----------------------------------------------------------------------------
package vnorm_pkg;

  localparam int COMP_WIDTH_DEF = 32;

  // Register map, byte addresses.
  localparam logic [1:0] ADDR_ZERO_MARGIN = 2'd0;

  localparam logic [15:0] ZERO_MARGIN_RST = 16'd1;

endpackage
// ----------------------------------------------------------------------------

FILE: hdl/vector2_normalize.sv
// ----------------------------------------------------------------------------
// vector2_normalize: pipelined 2D vector normalizer in fixed point
// Magnitude, squared magnitude and Q2.30 unit vector for each request.
// ----------------------------------------------------------------------------
// Usage
//   Each input request carries one vector (in_vec_x, in_vec_y) in signed
//   Q16.16; only the low COMP_WIDTH bits of each are used. A request is taken
//   at a rising edge with in_valid high and in_stall low. Each result request
//   carries the unit vector in Q2.30, the magnitude (floor of the square root)
//   in Q16.16, the exact squared magnitude in Q32.32 and a flag that is set,
//   with a zero unit vector, when the magnitude is at or below zero_margin.
//   One request enters every cycle while in_stall is low. A request passes
//   through stages for sign split, squaring and summing, a square root stage
//   for each root bit, a stage that forms the dividends, a divider stage for
//   each quotient bit of the two restoring dividers, and the output register.
//   Each stage holds a valid bit; a stage moves on when the stage after it
//   is empty or moving, so a stalled receiver stops only the full stages and
//   empty slots are squeezed out. Nothing is lost or repeated.
//   A synchronous active-low reset empties the pipeline and sets zero_margin
//   to 1. The user must write the register through the APB-style port only
//   while the pipeline is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module vector2_normalize
  import vnorm_pkg::*;
#(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_vec_x,
  input  logic [31:0] in_vec_y,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_unit_x,
  output logic [31:0] out_unit_y,
  output logic [31:0] out_length,
  output logic [63:0] out_length_squared,
  output logic        out_is_degenerate,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int W      = COMP_WIDTH;
  localparam int QW     = 31;               // quotient bits, result <= 2^30
  localparam int NW     = W + QW;           // dividend width
  localparam int SQ0    = 3;                // first square root stage
  localparam int DV0    = SQ0 + W + 1;      // first divider stage
  localparam int NS     = DV0 + QW + 1;     // total stages incl. output

  typedef struct packed {
    logic [W-1:0]   ax;
    logic [W-1:0]   ay;
    logic           nx;
    logic           ny;
    logic [2*W-1:0] sqx;
    logic [2*W-1:0] sqy;
    logic [2*W-1:0] sq;    // squared magnitude, kept for output
    logic [2*W-1:0] sqs;   // squared magnitude, shifted out two bits a stage
    logic [W+2:0]   srem;  // square root remainder
    logic [W-1:0]   root;
    logic           degen;
    logic [W:0]     rx;    // divider remainders
    logic [W:0]     ry;
    logic [QW-1:0]  lx;    // dividend bits still to shift in
    logic [QW-1:0]  ly;
    logic [QW-1:0]  qx;
    logic [QW-1:0]  qy;
    logic [31:0]    ux;
    logic [31:0]    uy;
  } stage_t;

  stage_t        pipe_r   [NS];
  stage_t        pipe_nxt [NS];
  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;
  logic [15:0]   zero_margin_r;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ZERO_MARGIN) ? {16'd0, zero_margin_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_margin_r <= ZERO_MARGIN_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_ZERO_MARGIN) begin
      zero_margin_r <= pwdata[15:0];
    end
  end

  // A stage may load when it is empty or its contents move on.
  always_comb begin
    en[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  always_comb begin
    logic [W-1:0]   vx;
    logic [W-1:0]   vy;
    logic [W+2:0]   t;
    logic [W+2:0]   tst;
    logic [W:0]     dx;
    logic [W:0]     dy;
    logic [W:0]     lenx;
    logic [NW-1:0]  numx;
    logic [NW-1:0]  numy;
    logic [31:0]    lenz;
    vx   = in_vec_x[W-1:0];
    vy   = in_vec_y[W-1:0];
    t    = '0;
    tst  = '0;
    dx   = '0;
    dy   = '0;
    lenx = '0;
    numx = '0;
    numy = '0;
    lenz = '0;
    for (int i = 0; i < NS; i++) begin
      if (i == 0) begin
        pipe_nxt[i]    = pipe_r[i];
        pipe_nxt[i].nx = vx[W-1];
        pipe_nxt[i].ny = vy[W-1];
        pipe_nxt[i].ax = vx[W-1] ? (~vx + 1'b1) : vx;
        pipe_nxt[i].ay = vy[W-1] ? (~vy + 1'b1) : vy;
      end else begin
        pipe_nxt[i] = pipe_r[i-1];
        if (i == 1) begin
          pipe_nxt[i].sqx = pipe_r[i-1].ax * pipe_r[i-1].ax;
          pipe_nxt[i].sqy = pipe_r[i-1].ay * pipe_r[i-1].ay;
        end else if (i == 2) begin
          pipe_nxt[i].sq   = pipe_r[i-1].sqx + pipe_r[i-1].sqy;
          pipe_nxt[i].sqs  = pipe_r[i-1].sqx + pipe_r[i-1].sqy;
          pipe_nxt[i].srem = '0;
          pipe_nxt[i].root = '0;
        end else if (i < SQ0 + W) begin
          // One root bit: bring down two radicand bits and try 4*root + 1.
          t   = {pipe_r[i-1].srem[W:0], pipe_r[i-1].sqs[2*W-1 -: 2]};
          tst = {1'b0, pipe_r[i-1].root, 2'b01};
          pipe_nxt[i].sqs = pipe_r[i-1].sqs << 2;
          if (t >= tst) begin
            pipe_nxt[i].srem = t - tst;
            pipe_nxt[i].root = {pipe_r[i-1].root[W-2:0], 1'b1};
          end else begin
            pipe_nxt[i].srem = t;
            pipe_nxt[i].root = {pipe_r[i-1].root[W-2:0], 1'b0};
          end
        end else if (i == SQ0 + W) begin
          // Rounded dividends |c| * 2^30 + length / 2.
          lenz = 32'(pipe_r[i-1].root);
          pipe_nxt[i].degen = lenz <= {16'd0, zero_margin_r};
          numx = {1'b0, pipe_r[i-1].ax, 30'd0} + NW'(pipe_r[i-1].root >> 1);
          numy = {1'b0, pipe_r[i-1].ay, 30'd0} + NW'(pipe_r[i-1].root >> 1);
          pipe_nxt[i].rx = {1'b0, numx[NW-1:QW]};
          pipe_nxt[i].ry = {1'b0, numy[NW-1:QW]};
          pipe_nxt[i].lx = numx[QW-1:0];
          pipe_nxt[i].ly = numy[QW-1:0];
          pipe_nxt[i].qx = '0;
          pipe_nxt[i].qy = '0;
        end else if (i < DV0 + QW) begin
          // One quotient bit for each component.
          lenx = {1'b0, pipe_r[i-1].root};
          dx   = {pipe_r[i-1].rx[W-1:0], pipe_r[i-1].lx[QW-1]};
          dy   = {pipe_r[i-1].ry[W-1:0], pipe_r[i-1].ly[QW-1]};
          pipe_nxt[i].lx = pipe_r[i-1].lx << 1;
          pipe_nxt[i].ly = pipe_r[i-1].ly << 1;
          pipe_nxt[i].rx = (dx >= lenx) ? dx - lenx : dx;
          pipe_nxt[i].ry = (dy >= lenx) ? dy - lenx : dy;
          pipe_nxt[i].qx = {pipe_r[i-1].qx[QW-2:0], dx >= lenx};
          pipe_nxt[i].qy = {pipe_r[i-1].qy[QW-2:0], dy >= lenx};
        end else begin
          if (pipe_r[i-1].degen) begin
            pipe_nxt[i].ux = '0;
            pipe_nxt[i].uy = '0;
          end else begin
            pipe_nxt[i].ux = pipe_r[i-1].nx ? (32'd0 - {1'b0, pipe_r[i-1].qx})
                                            : {1'b0, pipe_r[i-1].qx};
            pipe_nxt[i].uy = pipe_r[i-1].ny ? (32'd0 - {1'b0, pipe_r[i-1].qy})
                                            : {1'b0, pipe_r[i-1].qy};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (en[i]) begin
        pipe_r[i] <= pipe_nxt[i];
      end
    end
  end

  assign out_valid          = vld_r[NS-1];
  assign out_unit_x         = pipe_r[NS-1].ux;
  assign out_unit_y         = pipe_r[NS-1].uy;
  assign out_length         = 32'(pipe_r[NS-1].root);
  assign out_length_squared = 64'(pipe_r[NS-1].sq);
  assign out_is_degenerate  = pipe_r[NS-1].degen;

endmodule
// ----------------------------------------------------------------------------

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 2D vector normalizer
// Drives vectors through the valid/stall channel with random idling, predicts
// each result in the bench and compares it field by field. The zero margin
// is rewritten between phases, when the pipeline is idle.
// ----------------------------------------------------------------------------
module tb;
  import vnorm_pkg::*;

  localparam int CW        = COMP_WIDTH_DEF;
  localparam int LATENCY   = CW + 36;
  localparam int MAX_CYCLE = 400000;

  // One predicted result.
  typedef struct packed {
    logic [31:0] unit_x;
    logic [31:0] unit_y;
    logic [31:0] length;
    logic [63:0] length_squared;
    logic        is_degenerate;
  } norm_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_vec_x = '0;
  logic [31:0] in_vec_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_unit_x;
  logic [31:0] out_unit_y;
  logic [31:0] out_length;
  logic [63:0] out_length_squared;
  logic        out_is_degenerate;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vector2_normalize DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_unit_x(out_unit_x), .out_unit_y(out_unit_y),
    .out_length(out_length), .out_length_squared(out_length_squared),
    .out_is_degenerate(out_is_degenerate),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Bench copy of the single register.
  logic [15:0]  margin_shadow = ZERO_MARGIN_RST;
  norm_result_t pending_results[$];
  int           error_count = 0;
  int           results_seen = 0;
  int           degenerate_seen = 0;
  int           cycle_count = 0;
  bit           idle_enable = 1'b1;

  // Magnitude of the low CW bits read as two's complement.
  function automatic logic [63:0] comp_mag(input logic [31:0] raw, output bit neg);
    logic [63:0] v;
    v = {32'd0, raw} & ((64'd1 << CW) - 64'd1);
    neg = v[CW-1];
    return neg ? (64'd1 << CW) - v : v;
  endfunction

  // Bitwise integer square root, rounded down.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Rounded quotient |c| * 2^30 / len, carrying the sign of c.
  function automatic logic [31:0] unit_comp(input logic [63:0] mag, input bit neg,
                                            input logic [63:0] len);
    logic [63:0] q;
    if (len == 0) return 32'd0;
    q = ((mag << 30) + (len >> 1)) / len;
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic norm_result_t predict_norm(input logic [31:0] x, input logic [31:0] y);
    norm_result_t r;
    logic [63:0] ax, ay, sq, len;
    bit nx, ny;
    ax = comp_mag(x, nx);
    ay = comp_mag(y, ny);
    sq = ax * ax + ay * ay;
    len = floor_sqrt(sq);
    r.is_degenerate = (len <= {48'd0, margin_shadow});
    r.unit_x = r.is_degenerate ? 32'd0 : unit_comp(ax, nx, len);
    r.unit_y = r.is_degenerate ? 32'd0 : unit_comp(ay, ny, len);
    r.length = len[31:0];
    r.length_squared = sq;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  // Result checker: samples each accepted result at the rising edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_length_squared, 64'd0);
      end else begin
        norm_result_t e;
        e = pending_results.pop_front();
        results_seen++;
        if (e.is_degenerate) degenerate_seen++;
        if (out_unit_x !== e.unit_x) report_mismatch("unit_x", out_unit_x, e.unit_x);
        if (out_unit_y !== e.unit_y) report_mismatch("unit_y", out_unit_y, e.unit_y);
        if (out_length !== e.length) report_mismatch("length", out_length, e.length);
        if (out_length_squared !== e.length_squared)
          report_mismatch("length_squared", out_length_squared, e.length_squared);
        if (out_is_degenerate !== e.is_degenerate)
          report_mismatch("is_degenerate", out_is_degenerate, e.is_degenerate);
      end
    end
  end

  // Receiver stall bursts, switched off in the last part of the run.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (idle_enable && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Watchdog on the cycle counter.
  always @(posedge clk) begin
    if (cycle_count > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Sends one request and waits until it is accepted. The prediction is made
  // at acceptance, with the register value that applies to it.
  task automatic send_vector(input logic [31:0] x, input logic [31:0] y);
    int gap;
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_vec_x <= x;
    in_vec_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_norm(x, y));
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // Waits for the pipeline to drain before a register write.
  task automatic wait_drained();
    stop_sending();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Setup cycle then access cycle; the write lands on the access edge.
  task automatic write_margin(input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ZERO_MARGIN;
    pwdata <= {16'($urandom_range(0, 65535)), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    margin_shadow = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Random component: mostly small magnitudes, some full-range.
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 8) - 4;
      2: return $signed($urandom_range(0, 262143)) - 131072;
      default: return $urandom() >>> $urandom_range(0, 31);
    endcase
  endfunction

  // Extremes, the most negative input, zero and vectors near the margin.
  task automatic test_directed();
    send_vector(32'h0, 32'h0);
    send_vector(32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h8000_0000, 32'h0);
    send_vector(32'h0, 32'h7FFF_FFFF);
    send_vector(32'h1, 32'h0);
    send_vector(32'h2, 32'h0);
    send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vector(32'h0001_0000, 32'h0);
    send_vector(32'hFFFF_0000, 32'h0001_0000);
    send_vector(32'h0003_0000, 32'hFFFC_0000);
    send_vector(32'h5555_5555, 32'hAAAA_AAAA);
    send_vector(32'h0, 32'hFFFF_FFFE);
  endtask

  // Vectors near the configured margin, on both sides of it, mixed with random vectors.
  task automatic test_margin(input logic [15:0] value, input int count);
    wait_drained();
    write_margin(value);
    send_vector({16'd0, value}, 32'd0);
    send_vector({16'd0, value} + 32'd1, 32'd0);
    send_vector(-{16'd0, value}, 32'd0);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1))
        send_vector($signed({16'd0, value}) + $signed($urandom_range(0, 6)) - 3,
                    $urandom_range(0, 3) - 1);
      else
        send_vector(rand_comp(), rand_comp());
    end
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_vector(rand_comp(), rand_comp());
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(500);
    test_margin(16'd0, 200);
    test_margin(16'hFFFF, 300);
    test_margin(16'd1000, 300);
    test_margin(16'h8000, 200);
    test_margin(16'd1, 100);
    idle_enable = 1'b0;
    test_random(300);
    stop_sending();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    $display("checked %0d results, %0d of them degenerate, over six margin settings",
             results_seen, degenerate_seen);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
